// ===== rtl/core/mrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrf_pkg
// Types, constants and the CRC-16 byte update shared by the request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

   localparam int unsigned MAX_WORDS  = 123;
   localparam int unsigned BUF_BYTES  = 9;
   localparam int unsigned HDR_WM_LEN = 7;
   localparam int unsigned FULL_LEN   = 6;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  SLAVE_RESET = 8'h01;

   typedef enum logic [1:0] {
      OP_READ_HOLDING   = 2'd0,
      OP_READ_INPUT     = 2'd1,
      OP_WRITE_SINGLE   = 2'd2,
      OP_WRITE_MULTIPLE = 2'd3
   } op_type;

   localparam logic [7:0] FUNC_CODE [4] = '{8'h03, 8'h04, 8'h06, 8'h10};

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] start_address;
      logic [15:0] quantity;
      logic [15:0] data_word;
   } item_type;

   typedef struct packed {
      logic       open;
      logic [6:0] expected;
      logic [6:0] sent;
   } frame_state_type;

   // bytes[0] goes out first
   typedef struct packed {
      logic [BUF_BYTES-1:0][7:0] bytes;
      logic [3:0]                count;
      logic                      with_crc;
   } load_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/mrf_req_if.sv =====
// ----------------------------------------------------------------------------
// mrf_req_if
// Request item channel: valid/ready plus the request fields.
// ----------------------------------------------------------------------------
interface mrf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] start_address;
   logic [15:0] quantity;
   logic [15:0] data_word;

   modport source (output valid, output op, output start_address, output quantity,
                   output data_word, input ready);
   modport sink   (input valid, input op, input start_address, input quantity,
                   input data_word, output ready);
endinterface

// ===== rtl/core/mrf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mrf_rsp_if
// Frame byte channel: valid/ready plus one byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface mrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== rtl/core/mrf_csr_if.sv =====
// ----------------------------------------------------------------------------
// mrf_csr_if
// Register write channel carrying the slave address.
// ----------------------------------------------------------------------------
interface mrf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mrf_frame_build.sv =====
// ----------------------------------------------------------------------------
// mrf_frame_build
// Lays out the frame bytes one request item produces and the next frame state.
// ----------------------------------------------------------------------------
module mrf_frame_build (
   input  mrf_pkg::item_type        item,
   input  logic [7:0]               slave_address,
   input  mrf_pkg::frame_state_type frame_st,
   output mrf_pkg::load_type        load_data,
   output mrf_pkg::frame_state_type frame_st_in
);

   logic [6:0] sent_n;
   logic [6:0] q;

   always_comb begin
      load_data   = '0;
      frame_st_in = frame_st;
      sent_n      = frame_st.sent + 7'd1;
      q           = (item.quantity > 16'(mrf_pkg::MAX_WORDS)) ?
                    7'(mrf_pkg::MAX_WORDS) : item.quantity[6:0];
      if (frame_st.open) begin
         // continuation of a write-multiple: data word only
         load_data.bytes[0] = item.data_word[15:8];
         load_data.bytes[1] = item.data_word[7:0];
         load_data.count    = 4'd2;
         if (sent_n >= frame_st.expected) begin
            load_data.with_crc = 1'b1;
            frame_st_in        = '0;
         end else begin
            frame_st_in.sent = sent_n;
         end
      end else begin
         load_data.bytes[0] = slave_address;
         load_data.bytes[1] = mrf_pkg::FUNC_CODE[item.op];
         load_data.bytes[2] = item.start_address[15:8];
         load_data.bytes[3] = item.start_address[7:0];
         load_data.with_crc = 1'b1;
         load_data.count    = 4'(mrf_pkg::FULL_LEN);
         case (mrf_pkg::op_type'(item.op))
            mrf_pkg::OP_READ_HOLDING, mrf_pkg::OP_READ_INPUT: begin
               load_data.bytes[4] = item.quantity[15:8];
               load_data.bytes[5] = item.quantity[7:0];
            end
            mrf_pkg::OP_WRITE_SINGLE: begin
               load_data.bytes[4] = item.data_word[15:8];
               load_data.bytes[5] = item.data_word[7:0];
            end
            mrf_pkg::OP_WRITE_MULTIPLE: begin
               load_data.bytes[4] = 8'h00;
               load_data.bytes[5] = {1'b0, q};
               load_data.bytes[6] = {q, 1'b0};
               load_data.count    = 4'(mrf_pkg::HDR_WM_LEN);
               if (q != 7'd0) begin
                  load_data.bytes[7] = item.data_word[15:8];
                  load_data.bytes[8] = item.data_word[7:0];
                  load_data.count    = 4'(mrf_pkg::BUF_BYTES);
                  if (q != 7'd1) begin
                     load_data.with_crc   = 1'b0;
                     frame_st_in.open     = 1'b1;
                     frame_st_in.expected = q;
                     frame_st_in.sent     = 7'd1;
                  end
               end
            end
            default: begin
               load_data = '0;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/mrf_byte_serializer.sv =====
// ----------------------------------------------------------------------------
// mrf_byte_serializer
// Shifts out frame bytes one per cycle while rsp takes them, keeps the running CRC, appends it.
// ----------------------------------------------------------------------------
module mrf_byte_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  mrf_pkg::load_type load_data,
   output logic              can_load,
   mrf_rsp_if.source         rsp
);

   logic [mrf_pkg::BUF_BYTES-1:0][7:0] buf_ff, buf_in;
   logic [3:0]  data_left_ff, data_left_in;
   logic [1:0]  crc_left_ff, crc_left_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_end_ff, out_end_in;
   logic        busy, advance, last, emit_crc_hi;

   assign busy        = (data_left_ff != 4'd0) || (crc_left_ff != 2'd0);
   assign advance     = busy && (!out_valid_ff || rsp.ready);
   assign last        = ((data_left_ff == 4'd1) && (crc_left_ff == 2'd0)) ||
                        ((data_left_ff == 4'd0) && (crc_left_ff == 2'd1));
   assign can_load    = !busy || (advance && last);
   assign emit_crc_hi = advance && (data_left_ff == 4'd0) && (crc_left_ff == 2'd1);

   always_comb begin
      buf_in       = buf_ff;
      data_left_in = data_left_ff;
      crc_left_in  = crc_left_ff;
      crc_in       = crc_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (advance) begin
         out_valid_in = 1'b1;
         if (data_left_ff != 4'd0) begin
            out_byte_in  = buf_ff[0];
            out_end_in   = 1'b0;
            crc_in       = mrf_pkg::crc16_byte(crc_ff, buf_ff[0]);
            buf_in       = {8'h00, buf_ff[mrf_pkg::BUF_BYTES-1:1]};
            data_left_in = data_left_ff - 4'd1;
         end else if (crc_left_ff == 2'd2) begin
            out_byte_in = crc_ff[7:0];
            out_end_in  = 1'b0;
            crc_left_in = 2'd1;
         end else begin
            out_byte_in = crc_ff[15:8];
            out_end_in  = 1'b1;
            crc_in      = mrf_pkg::CRC_INIT;
            crc_left_in = 2'd0;
         end
      end
      if (load) begin
         buf_in       = load_data.bytes;
         data_left_in = load_data.count;
         crc_left_in  = load_data.with_crc ? 2'd2 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_left_ff <= '0;
         crc_left_ff  <= '0;
         crc_ff       <= mrf_pkg::CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         data_left_ff <= data_left_in;
         crc_left_ff  <= crc_left_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
      buf_ff      <= buf_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.frame_byte = out_byte_ff;
   assign rsp.frame_end  = out_end_ff;

   // the crc restarts once the closing byte has gone out
   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      emit_crc_hi |=> (crc_ff == mrf_pkg::CRC_INIT))
      else $error("crc not restarted after frame end");

   // a new item is only taken once the current byte run is finishing
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (load && busy) |-> (advance && last))
      else $error("serializer loaded while bytes remain");

endmodule

// ===== rtl/core/modbus_rtu_request_framer.sv =====
// A request is registered, laid out into the byte shifter once the shifter can take it, and
// its first frame byte then leaves from the registered rsp output.
// The byte shifter sends one frame byte per cycle while rsp is ready: 8 bytes for a read or
// write-single item, 9 or 11 for a write-multiple opening item and 2 or 4 for a continuation.
// Reset: synchronous; slave address returns to 1, the crc to 0xFFFF, no frame is open.
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Modbus RTU master request framer: request items in, frame bytes with CRC out.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer (
   input  logic      clock,
   input  logic      reset,
   mrf_req_if.sink   req,
   mrf_rsp_if.source rsp,
   mrf_csr_if.sink   csr
);

   mrf_pkg::item_type        item_ff, item_in;
   logic                     item_valid_ff, item_valid_in;
   mrf_pkg::frame_state_type frame_ff, frame_in, frame_next;
   logic [7:0]               slave_ff, slave_in;
   mrf_pkg::load_type        load_data;
   logic                     can_load, load;

   assign load      = item_valid_ff && can_load;
   assign req.ready = !item_valid_ff || load;
   assign csr.ready = 1'b1;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !load;
      if (req.valid && req.ready) begin
         item_in.op            = req.op;
         item_in.start_address = req.start_address;
         item_in.quantity      = req.quantity;
         item_in.data_word     = req.data_word;
         item_valid_in         = 1'b1;
      end
      frame_in = load ? frame_next : frame_ff;
      slave_in = csr.valid ? csr.data : slave_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         frame_ff      <= '0;
         slave_ff      <= mrf_pkg::SLAVE_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         frame_ff      <= frame_in;
         slave_ff      <= slave_in;
      end
      item_ff <= item_in;
   end

   mrf_frame_build u_build (
      .item          (item_ff),
      .slave_address (slave_ff),
      .frame_st      (frame_ff),
      .load_data     (load_data),
      .frame_st_in   (frame_next)
   );

   mrf_byte_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (load_data),
      .can_load  (can_load),
      .rsp       (rsp)
   );

   // an open write-multiple frame always has words still to come
   a_open_words_left: assert property (@(posedge clock) disable iff (reset)
      frame_ff.open |-> (frame_ff.sent < frame_ff.expected))
      else $error("open frame with no words left");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      frame_ff.open |-> (frame_ff.expected <= 7'(mrf_pkg::MAX_WORDS)))
      else $error("word count above limit");

endmodule

// ===== tb/sv/tb_modbus_rtu_request_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_request_framer
// Self-checking bench for the request framer. Request items go in over the
// req channel and the frame bytes coming back are checked one by one. The
// expected frames, CRC included, are rebuilt here from the items accepted.
// The bench covers reads, write-single, empty, short and saturated
// write-multiple frames, and several slave addresses and back-pressure mixes.
// ----------------------------------------------------------------------------

localparam logic [7:0]  FC_READ_HOLDING    = 8'h03;
localparam logic [7:0]  FC_READ_INPUT      = 8'h04;
localparam logic [7:0]  FC_WRITE_SINGLE    = 8'h06;
localparam logic [7:0]  FC_WRITE_MULTIPLE  = 8'h10;
localparam logic [15:0] CRC_SEED           = 16'hFFFF;
localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
localparam logic [15:0] WORD_LIMIT         = 16'd123;
localparam logic [7:0]  SLAVE_AFTER_RESET  = 8'h01;

typedef struct packed {
   logic [7:0] value;
   logic       last;
} frame_byte_type;

class frame_tracker;
   logic [7:0]     slave_addr;
   logic [15:0]    crc;
   logic [6:0]     words_due;
   logic [6:0]     words_done;
   logic           frame_is_open;
   frame_byte_type bytes_due[$];
   int unsigned    errors;
   int unsigned    bytes_checked;
   int unsigned    frames_built;

   function new();
      slave_addr    = SLAVE_AFTER_RESET;
      crc           = CRC_SEED;
      words_due     = '0;
      words_done    = '0;
      frame_is_open = 1'b0;
      errors        = 0;
      bytes_checked = 0;
      frames_built  = 0;
   endfunction

   // bitwise reflected crc-16, one data bit per step
   function logic [15:0] crc_after(logic [15:0] acc, logic [7:0] b);
      logic fb;
      for (int k = 0; k < 8; k++) begin
         fb  = acc[0] ^ b[k];
         acc = acc >> 1;
         if (fb) begin
            acc = acc ^ CRC_REFLECTED_POLY;
         end
      end
      return acc;
   endfunction

   function void push_byte(logic [7:0] b);
      crc = crc_after(crc, b);
      bytes_due.push_back('{value: b, last: 1'b0});
   endfunction

   function void push_word(logic [15:0] w);
      push_byte(w[15:8]);
      push_byte(w[7:0]);
   endfunction

   function void close_frame();
      bytes_due.push_back('{value: crc[7:0], last: 1'b0});
      bytes_due.push_back('{value: crc[15:8], last: 1'b1});
      crc           = CRC_SEED;
      frame_is_open = 1'b0;
      words_due     = '0;
      words_done    = '0;
      frames_built++;
   endfunction

   function void note_request(mrf_pkg::item_type it);
      logic [15:0] q;
      logic [7:0]  fc;
      // an open write-multiple frame takes only the data word
      if (frame_is_open) begin
         push_word(it.data_word);
         words_done = words_done + 7'd1;
         if (words_done >= words_due) begin
            close_frame();
         end
         return;
      end
      case (mrf_pkg::op_type'(it.op))
         mrf_pkg::OP_READ_HOLDING: fc = FC_READ_HOLDING;
         mrf_pkg::OP_READ_INPUT:   fc = FC_READ_INPUT;
         mrf_pkg::OP_WRITE_SINGLE: fc = FC_WRITE_SINGLE;
         default:                  fc = FC_WRITE_MULTIPLE;
      endcase
      crc = CRC_SEED;
      push_byte(slave_addr);
      push_byte(fc);
      push_word(it.start_address);
      case (mrf_pkg::op_type'(it.op))
         mrf_pkg::OP_READ_HOLDING, mrf_pkg::OP_READ_INPUT: begin
            push_word(it.quantity);
            close_frame();
         end
         mrf_pkg::OP_WRITE_SINGLE: begin
            push_word(it.data_word);
            close_frame();
         end
         default: begin
            q = (it.quantity > WORD_LIMIT) ? WORD_LIMIT : it.quantity;
            push_word(q);
            push_byte(8'(q << 1));
            if (q == 16'd0) begin
               close_frame();
            end else begin
               push_word(it.data_word);
               if (q == 16'd1) begin
                  close_frame();
               end else begin
                  words_due     = q[6:0];
                  words_done    = 7'd1;
                  frame_is_open = 1'b1;
               end
            end
         end
      endcase
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task check_byte(logic [7:0] value, logic last);
      frame_byte_type want;
      if (bytes_due.size() == 0) begin
         report($sformatf("frame byte %02h (end %0b) with nothing expected", value, last));
         return;
      end
      want = bytes_due.pop_front();
      if (value !== want.value) begin
         report($sformatf("byte %0d: frame_byte %02h, expected %02h",
                          bytes_checked, value, want.value));
      end
      if (last !== want.last) begin
         report($sformatf("byte %0d: frame_end %0b, expected %0b",
                          bytes_checked, last, want.last));
      end
      bytes_checked++;
   endtask
endclass

module tb_modbus_rtu_request_framer;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS = 16;

   logic         clock;
   logic         reset;
   int unsigned  send_idle_pct;
   int unsigned  rsp_stall_pct;
   int unsigned  items_sent;
   int unsigned  idle_cycles;
   int unsigned  slave_settings;
   frame_tracker frames;

   mrf_req_if req_ch();
   mrf_rsp_if rsp_ch();
   mrf_csr_if csr_ch();

   modbus_rtu_request_framer u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // observe every transfer at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            frames.slave_addr = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready) begin
            frames.note_request({req_ch.op, req_ch.start_address, req_ch.quantity,
                                 req_ch.data_word});
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            frames.check_byte(rsp_ch.frame_byte, rsp_ch.frame_end);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d bytes still due",
                  idle_cycles, frames.bytes_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic mrf_pkg::item_type make_item(mrf_pkg::op_type op, logic [15:0] addr,
                                                   logic [15:0] qty, logic [15:0] data);
      mrf_pkg::item_type r;
      r.op            = op;
      r.start_address = addr;
      r.quantity      = qty;
      r.data_word     = data;
      return r;
   endfunction

   function automatic logic [15:0] edge_biased_word();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(mrf_pkg::item_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.op            <= it.op;
      req_ch.start_address <= it.start_address;
      req_ch.quantity      <= it.quantity;
      req_ch.data_word     <= it.data_word;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // continuation items carry random op, address and quantity on purpose
   task automatic send_continuations(int unsigned n);
      for (int unsigned k = 0; k < n; k++) begin
         send_item(make_item(mrf_pkg::op_type'($urandom_range(0, 3)), edge_biased_word(),
                             edge_biased_word(), edge_biased_word()));
      end
   endtask

   task automatic write_slave(logic [7:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      slave_settings++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (frames.bytes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_frame();
      mrf_pkg::item_type it;
      int unsigned       q;
      it = make_item(mrf_pkg::op_type'($urandom_range(0, 3)), edge_biased_word(),
                     edge_biased_word(), edge_biased_word());
      if (mrf_pkg::op_type'(it.op) == mrf_pkg::OP_WRITE_MULTIPLE) begin
         case ($urandom_range(0, 9))
            0:       q = 0;
            1:       q = 1;
            8, 9:    q = $urandom_range(7, 20);
            default: q = $urandom_range(2, 6);
         endcase
         it.quantity = 16'(q);
         send_item(it);
         if (q >= 2) begin
            send_continuations(q - 1);
         end
      end else begin
         send_item(it);
      end
   endtask

   task automatic send_directed();
      send_item(make_item(mrf_pkg::OP_READ_HOLDING, 16'h0000, 16'h0000, 16'h0000));
      send_item(make_item(mrf_pkg::OP_READ_HOLDING, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(make_item(mrf_pkg::OP_READ_INPUT, 16'h0000, 16'hFFFF, 16'h5A5A));
      send_item(make_item(mrf_pkg::OP_READ_INPUT, 16'hFFFF, 16'h0000, 16'h0000));
      // write-single ignores the quantity
      send_item(make_item(mrf_pkg::OP_WRITE_SINGLE, 16'h0001, 16'hFFFF, 16'hABCD));
      send_item(make_item(mrf_pkg::OP_WRITE_SINGLE, 16'hFFFF, 16'h0000, 16'h0000));
      send_item(make_item(mrf_pkg::OP_WRITE_SINGLE, 16'h0000, 16'h1234, 16'hFFFF));
      // empty write-multiple, data word unused
      send_item(make_item(mrf_pkg::OP_WRITE_MULTIPLE, 16'h1000, 16'h0000, 16'hBEEF));
      send_item(make_item(mrf_pkg::OP_WRITE_MULTIPLE, 16'h2000, 16'h0001, 16'h1234));
      send_item(make_item(mrf_pkg::OP_WRITE_MULTIPLE, 16'hFFFF, 16'h0002, 16'hFFFF));
      send_item(make_item(mrf_pkg::OP_READ_HOLDING, 16'h0000, 16'h0000, 16'h0000));
      send_item(make_item(mrf_pkg::OP_WRITE_MULTIPLE, 16'h0000, 16'h0003, 16'h0001));
      send_item(make_item(mrf_pkg::OP_WRITE_SINGLE, 16'hFFFF, 16'hFFFF, 16'h8000));
      send_item(make_item(mrf_pkg::OP_WRITE_MULTIPLE, 16'h55AA, 16'h0002, 16'h7FFF));
      // quantity far above the limit saturates to the full 123 words
      send_item(make_item(mrf_pkg::OP_WRITE_MULTIPLE, 16'h0100, 16'hFFFF, 16'hC0DE));
      send_continuations(WORD_LIMIT - 1);
      send_item(make_item(mrf_pkg::OP_READ_INPUT, 16'h1234, 16'h007D, 16'h0000));
   endtask

   initial begin
      int unsigned phase_start;
      frames               = new();
      reset                = 1'b1;
      send_idle_pct        = 0;
      rsp_stall_pct        = 0;
      items_sent           = 0;
      slave_settings       = 0;
      req_ch.valid         = 1'b0;
      req_ch.op            = '0;
      req_ch.start_address = '0;
      req_ch.quantity      = '0;
      req_ch.data_word     = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.data          = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_slave(8'h00);
      send_directed();
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               write_slave(8'hFF);
            end
            1: begin
               send_idle_pct = 49;
               rsp_stall_pct = 0;
               write_slave(8'($urandom));
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 49;
               write_slave(SLAVE_AFTER_RESET);
            end
            default: begin
               send_idle_pct = 8;
               rsp_stall_pct = 8;
               write_slave(8'($urandom));
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            send_random_frame();
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d request items in %0d frames, %0d frame bytes checked",
               items_sent, frames.frames_built, frames.bytes_checked);
      $display("%0d slave address settings, back-pressure off, sender, receiver, both",
               slave_settings);
      if (frames.errors == 0 && frames.bytes_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
